// ----- rtl/masked_mahalanobis_distance_unit_assert.svh -----
// assertion macros used by the top rtl file
`ifndef MASKED_MAHALANOBIS_DISTANCE_UNIT_ASSERT_SVH
`define MASKED_MAHALANOBIS_DISTANCE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define MMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mmd_pkg.sv -----
`timescale 1ns / 1ps

package mmd_pkg;

   // fixed field widths of the ports
   localparam int MODE_W      = 2;
   localparam int IDX_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int DIST_W      = 63;
   localparam int LEN_W       = 5;
   localparam int MASK_W      = 16;
   localparam int MASK_IDX_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MATRIX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_MASK  = 2'd1;

   localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd16;
   localparam logic [MASK_W-1:0] MASK_RESET = 16'd0;

   // sequencer to accumulator controls
   typedef struct packed {
      logic row_clear;
      logic row_add;
      logic row_sat_load;
      logic quad_clear;
      logic quad_add;
      logic finish;
   } acc_ctrl_type;

endpackage

// ----- rtl/mmd_mul.sv -----
`timescale 1ns / 1ps

module mmd_mul #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic signed [WIDTH-1:0]   op_a,
   input  logic signed [WIDTH-1:0]   op_b,
   output logic signed [2*WIDTH-1:0] product
);

   logic signed [2*WIDTH-1:0] product_ff;

   // full precision signed product, registered
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

// ----- rtl/mmd_acc.sv -----
`timescale 1ns / 1ps

module mmd_acc #(
   parameter int MAX_LEN    = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mmd_pkg::acc_ctrl_type          ctrl,
   input  logic signed [2*VALUE_BITS-1:0] product,
   output logic signed [VALUE_BITS-1:0]   row_sat,
   output logic [mmd_pkg::DIST_W-1:0]     distance
);

   import mmd_pkg::*;

   localparam int LW     = $clog2(MAX_LEN) + 1;
   localparam int PW     = 2 * VALUE_BITS;
   localparam int ROW_W  = PW - 16 + LW;
   localparam int QW0    = PW + LW;
   localparam int QUAD_W = (QW0 > DIST_W + 1) ? QW0 : DIST_W + 1;

   logic signed [ROW_W-1:0]      row_sum_ff;
   logic signed [ROW_W-1:0]      row_term;
   logic signed [QUAD_W-1:0]     quad_ff;
   logic signed [QUAD_W-1:0]     quad_term;
   logic signed [QUAD_W-1:0]     quad_mag;
   logic                         row_fits;
   logic signed [VALUE_BITS-1:0] row_sat_ff;
   logic signed [VALUE_BITS-1:0] row_sat_in;
   logic [DIST_W-1:0]            distance_ff;
   logic [DIST_W-1:0]            distance_in;

   // dropping the low 16 bits of a signed product rounds toward minus infinity
   assign row_term  = {{LW{product[PW-1]}}, product[PW-1:16]};
   assign quad_term = {{(QUAD_W-PW){product[PW-1]}}, product};

   assign row_fits = (&row_sum_ff[ROW_W-1:VALUE_BITS-1]) |
                     (~|row_sum_ff[ROW_W-1:VALUE_BITS-1]);
   assign row_sat_in = row_fits ? row_sum_ff[VALUE_BITS-1:0] :
                       (row_sum_ff[ROW_W-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}} :
                                              {1'b0, {(VALUE_BITS-1){1'b1}}});

   assign quad_mag    = quad_ff[QUAD_W-1] ? -quad_ff : quad_ff;
   assign distance_in = (|quad_mag[QUAD_W-1:DIST_W]) ? {DIST_W{1'b1}} :
                                                        quad_mag[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
         quad_ff    <= '0;
      end else begin
         if (ctrl.row_clear) begin
            row_sum_ff <= '0;
         end else if (ctrl.row_add) begin
            row_sum_ff <= row_sum_ff + row_term;
         end
         if (ctrl.quad_clear) begin
            quad_ff <= '0;
         end else if (ctrl.quad_add) begin
            quad_ff <= quad_ff + quad_term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.row_sat_load) begin
         row_sat_ff <= row_sat_in;
      end
      if (ctrl.finish) begin
         distance_ff <= distance_in;
      end
   end

   assign row_sat  = row_sat_ff;
   assign distance = distance_ff;

endmodule

// ----- rtl/masked_mahalanobis_distance_unit.sv -----
`timescale 1ns / 1ps
// masked squared mahalanobis distance, q16.16 in, unsigned q31.32 out
// requests: start high while busy is low accepts one element request
//   (req_mode, req_row, req_col, req_value, req_last). query and matrix
//   elements and test elements without last are stored as they are accepted.
// a test element with last set launches the distance computation over the
//   first n = min(vector_length, MAX_LEN) elements; busy stays high meanwhile
// sequence: a difference pass over the n elements, then per row a check that
//   skips the row if its difference is zero, else n products on the shared
//   multiplier, pipeline drain and row term, then a finishing step; the
//   strobe follows in the cycle after it. one single multiplier is shared
//   by the products and the row terms
// results: rsp_valid is high for exactly one cycle with rsp_distance; the
//   receiver cannot stall and the next request may be taken in that cycle
// configuration: csr_write_en with csr_index and csr_wdata, written while idle
// reset (synchronous, active high): idle, vector_length 16, no mask bits.
//   stored vectors and matrix are undefined until written; no clearing pass
module masked_mahalanobis_distance_unit #(
   parameter int MAX_LEN    = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mmd_pkg::MODE_W-1:0]       req_mode,
   input  logic [mmd_pkg::IDX_W-1:0]        req_row,
   input  logic [mmd_pkg::IDX_W-1:0]        req_col,
   input  logic signed [mmd_pkg::VALUE_W-1:0] req_value,
   input  logic                             req_last,
   output logic                             rsp_valid,
   output logic [mmd_pkg::DIST_W-1:0]       rsp_distance,
   input  logic                             csr_write_en,
   input  logic [mmd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mmd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

`include "masked_mahalanobis_distance_unit_assert.svh"

   import mmd_pkg::*;

   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int VB = VALUE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF_RD,
      ST_DIFF_WR,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_MAC,
      ST_DRAIN,
      ST_TERM,
      ST_TERM_ACC,
      ST_FINISH
   } state_type;

   // sequencer state
   state_type         state_ff;
   logic              rsp_valid_ff;
   logic              p1_ff;         // memory read data valid for a product
   logic              p2_ff;         // multiplier output valid for a row sum
   logic [CW-1:0]     n_ff;
   logic [CW-1:0]     i_ff;          // element index, then row index
   logic [CW-1:0]     j_ff;          // column index
   logic [CW-1:0]     i_nxt;
   logic [CW-1:0]     j_nxt;
   logic              i_last;
   logic              j_last;
   logic [CW-1:0]     n_eff;

   // configuration
   logic [LEN_W-1:0]  vector_length_ff;
   logic [MASK_W-1:0] element_mask_ff;

   // storage
   logic [VB-1:0]     q_mem [MAX_LEN];
   logic [VB-1:0]     t_mem [MAX_LEN];
   logic [VB-1:0]     d_mem [MAX_LEN];
   logic [VB-1:0]     m_mem [MAX_LEN][MAX_LEN];

   logic signed [VB-1:0] q_rd_ff;
   logic signed [VB-1:0] t_rd_ff;
   logic signed [VB-1:0] d_rd_ff;
   logic signed [VB-1:0] m_rd_ff;
   logic signed [VB-1:0] d_i_ff;

   logic              accept;
   logic              launch;
   logic              row_ok;
   logic              col_ok;
   logic [IW-1:0]     wr_row;
   logic [IW-1:0]     wr_col;
   logic [VB-1:0]     wr_val;
   logic [IW-1:0]     i_idx;
   logic [IW-1:0]     j_idx;
   logic [IW-1:0]     d_raddr;

   logic signed [VB:0]   diff_wide;
   logic signed [VB-1:0] diff_sat;
   logic signed [VB-1:0] d_val;
   logic                 mask_hit;

   logic signed [VB-1:0]   mul_a;
   logic signed [VB-1:0]   mul_b;
   logic signed [2*VB-1:0] product;
   logic signed [VB-1:0]   row_sat;
   acc_ctrl_type           acc_ctrl;

   // request decode
   assign accept = start && !busy;
   assign launch = accept && (req_mode == MODE_TEST) && req_last;
   assign row_ok = int'(req_row) < MAX_LEN;
   assign col_ok = int'(req_col) < MAX_LEN;
   assign wr_row = IW'(req_row);
   assign wr_col = IW'(req_col);
   assign wr_val = req_value[VB-1:0];

   // effective length, clamped to the store depth
   assign n_eff = (int'(vector_length_ff) > MAX_LEN) ? CW'(MAX_LEN) :
                                                       CW'(vector_length_ff);

   assign i_nxt  = i_ff + CW'(1);
   assign j_nxt  = j_ff + CW'(1);
   assign i_last = (i_nxt == n_ff);
   assign j_last = (j_nxt == n_ff);
   assign i_idx  = i_ff[IW-1:0];
   assign j_idx  = j_ff[IW-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= LEN_RESET;
         element_mask_ff  <= MASK_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VECTOR_LENGTH: vector_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_ELEMENT_MASK:  element_mask_ff  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated, masked difference for element i
   assign diff_wide = {q_rd_ff[VB-1], q_rd_ff} - {t_rd_ff[VB-1], t_rd_ff};
   assign diff_sat  = (diff_wide[VB] == diff_wide[VB-1]) ? diff_wide[VB-1:0] :
                      (diff_wide[VB] ? {1'b1, {(VB-1){1'b0}}} :
                                       {1'b0, {(VB-1){1'b1}}});
   assign mask_hit  = (int'(i_ff) < MASK_W) && element_mask_ff[MASK_IDX_W'(i_ff)];
   assign d_val     = mask_hit ? '0 : diff_sat;

   // difference store is read at the row index, or the column while multiplying
   assign d_raddr = (state_ff == ST_MAC) ? j_idx : i_idx;

   // storage writes and registered reads
   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (req_mode)
            MODE_QUERY: begin
               if (row_ok) q_mem[wr_row] <= wr_val;
            end
            MODE_MATRIX: begin
               if (row_ok && col_ok) m_mem[wr_row][wr_col] <= wr_val;
            end
            MODE_TEST: begin
               if (row_ok) t_mem[wr_row] <= wr_val;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_DIFF_WR) begin
         d_mem[i_idx] <= d_val;
      end
      q_rd_ff <= q_mem[i_idx];
      t_rd_ff <= t_mem[i_idx];
      d_rd_ff <= d_mem[d_raddr];
      m_rd_ff <= m_mem[i_idx][j_idx];
      if (state_ff == ST_ROW_CHK) begin
         d_i_ff <= d_rd_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         p1_ff        <= (state_ff == ST_MAC);
         p2_ff        <= p1_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (launch) begin
                  n_ff     <= n_eff;
                  i_ff     <= '0;
                  state_ff <= (n_eff == '0) ? ST_FINISH : ST_DIFF_RD;
               end
            end
            ST_DIFF_RD: begin
               state_ff <= ST_DIFF_WR;
            end
            ST_DIFF_WR: begin
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= ST_ROW_RD;
               end else begin
                  i_ff     <= i_nxt;
                  state_ff <= ST_DIFF_RD;
               end
            end
            ST_ROW_RD: begin
               state_ff <= ST_ROW_CHK;
            end
            ST_ROW_CHK: begin
               // a zero difference contributes nothing: skip the row
               if (d_rd_ff == '0) begin
                  if (i_last) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     i_ff     <= i_nxt;
                     state_ff <= ST_ROW_RD;
                  end
               end else begin
                  j_ff     <= '0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               j_ff <= j_nxt;
               if (j_last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!p1_ff && !p2_ff) state_ff <= ST_TERM;
            end
            ST_TERM: begin
               state_ff <= ST_TERM_ACC;
            end
            ST_TERM_ACC: begin
               if (i_last) begin
                  state_ff <= ST_FINISH;
               end else begin
                  i_ff     <= i_nxt;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // accumulator controls
   always_comb begin
      acc_ctrl              = '0;
      acc_ctrl.quad_clear   = launch;
      acc_ctrl.row_clear    = (state_ff == ST_ROW_CHK) && (d_rd_ff != '0);
      acc_ctrl.row_add      = p2_ff;
      acc_ctrl.row_sat_load = (state_ff == ST_DRAIN) && !p1_ff && !p2_ff;
      acc_ctrl.quad_add     = (state_ff == ST_TERM_ACC);
      acc_ctrl.finish       = (state_ff == ST_FINISH);
   end

   // shared multiplier: matrix times difference, then row sum times d[i]
   assign mul_a = (state_ff == ST_TERM) ? row_sat : m_rd_ff;
   assign mul_b = (state_ff == ST_TERM) ? d_i_ff  : d_rd_ff;

   mmd_mul #(
      .WIDTH (VB)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   mmd_acc #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VB)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (acc_ctrl),
      .product  (product),
      .row_sat  (row_sat),
      .distance (rsp_distance)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MMD_ASSERT_NEXT(a_finish_strobe, clock, reset, state_ff == ST_FINISH, rsp_valid_ff && state_ff == ST_IDLE, "finish did not raise the strobe")
   `MMD_ASSERT_NOW(a_term_pipe_empty, clock, reset, state_ff == ST_TERM, !p1_ff && !p2_ff, "row term taken before the products drained")
   `MMD_ASSERT_NOW(a_col_in_range, clock, reset, state_ff == ST_MAC, j_ff < n_ff, "column index beyond length")
   `MMD_ASSERT_NOW(a_row_in_range, clock, reset, state_ff != ST_IDLE && state_ff != ST_FINISH, i_ff < n_ff, "row index beyond length")

endmodule
